[design/column_run_segmenter_defines.svh]
// ----------------------------------------------------------------------------
// Column run segmenter assertion macros
// Shared forms for the concurrent checks on the segmenter's ports.
// ----------------------------------------------------------------------------
`ifndef COLUMN_RUN_SEGMENTER_DEFINES_SVH
`define COLUMN_RUN_SEGMENTER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define CRS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/crs_pkg.sv]
// ----------------------------------------------------------------------------
// Column run segmenter package
// Word types, register indexes, widths and reset values shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

  localparam int COUNT_BITS          = 8;
  localparam int THRESH_BITS         = 8;
  localparam int SEG_BITS            = 11;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int CFG_DATA_BITS       = 11;
  localparam int MAX_COLUMNS_DEFAULT = 2048;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GREEN_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ROW_GAP     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_ROW_WIDTH   = 2'd2;

  localparam logic [THRESH_BITS-1:0] RESET_THRESHOLD = 8'd10;
  localparam logic [SEG_BITS-1:0]    RESET_GAP       = 11'd50;
  localparam logic [SEG_BITS-1:0]    RESET_MIN_WIDTH = 11'd20;

  typedef struct packed {
    logic [COUNT_BITS-1:0] green_count;
    logic                  last_column;
  } crs_column_t;

  typedef struct packed {
    logic [SEG_BITS-1:0] seg_start;
    logic [SEG_BITS-1:0] seg_end;
    logic                seg_valid;
    logic                section_done;
  } crs_result_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] green_threshold;
    logic [SEG_BITS-1:0]    max_row_gap;
    logic [SEG_BITS-1:0]    min_row_width;
  } crs_cfg_t;

endpackage

`default_nettype wire

[design/column_run_segmenter.sv]
// ----------------------------------------------------------------------------
// Column run segmenter
// Turns per-column green counts into merged column segments for a section.
// ----------------------------------------------------------------------------
// One word on the column channel carries a column's green count and a mark
// on the last column of the section. A word on the result channel carries a
// finished segment, a section end, or both. Columns that release no held
// segment give no result word; the last column always gives exactly one.
// A column word is taken into an input register, and its result is loaded
// from there into the output register as soon as that register is free or
// being read. One column is taken every cycle, limited only by the output
// register when the receiver stalls.
// While the result register is full and stalled, the input register holds
// the waiting column and col_stall rises; nothing is lost or repeated.
// Reset clears both registers, the run state and the column counter, and
// loads the threshold, gap and width registers with their default values.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module column_run_segmenter
  import crs_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      col_valid,
  output      logic                      col_stall,
  input  wire crs_column_t               col,
  output      logic                      res_valid,
  input  wire logic                      res_stall,
  output      crs_result_t               res,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  crs_cfg_t    cfg;
  crs_column_t item;
  crs_result_t res_next;
  logic        drain;
  logic        step;
  logic        res_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_threshold <= RESET_THRESHOLD;
      cfg.max_row_gap     <= RESET_GAP;
      cfg.min_row_width   <= RESET_MIN_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GREEN_THRESHOLD: cfg.green_threshold <= THRESH_BITS'(cfg_data);
        CFG_MAX_ROW_GAP:     cfg.max_row_gap     <= SEG_BITS'(cfg_data);
        CFG_MIN_ROW_WIDTH:   cfg.min_row_width   <= SEG_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  crs_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_stall (col_stall),
    .col       (col),
    .drain     (drain),
    .step      (step),
    .item      (item)
  );

  crs_core #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (step),
    .item        (item),
    .res_present (res_present),
    .res_next    (res_next)
  );

  crs_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .res_present (res_present),
    .res_next    (res_next),
    .drain       (drain),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

`default_nettype wire

[design/crs_in_reg.sv]
// ----------------------------------------------------------------------------
// Column input register
// Holds one accepted column word and releases it when the core steps.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_in_reg
  import crs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        col_valid,
  output      logic        col_stall,
  input  wire crs_column_t col,
  input  wire logic        drain,
  output      logic        step,
  output      crs_column_t item
);

  logic held;

  assign step      = held && drain;
  assign col_stall = held && !drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (col_valid && !col_stall) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (col_valid && !col_stall) begin
      item <= col;
    end
  end

endmodule

`default_nettype wire

[design/crs_core.sv]
// ----------------------------------------------------------------------------
// Column run segmenter core
// Run state, gap merge and the decision on the result of each column.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_core
  import crs_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire crs_cfg_t    cfg,
  input  wire logic        step,
  input  wire crs_column_t item,
  output      logic        res_present,
  output      crs_result_t res_next
);

  localparam int COL_BITS  = $clog2(MAX_COLUMNS);
  localparam int DIFF_BITS = (COL_BITS > SEG_BITS) ? COL_BITS : SEG_BITS;
  localparam logic [COL_BITS-1:0] LAST_INDEX = COL_BITS'(MAX_COLUMNS - 1);

  logic [COL_BITS-1:0]  column_index, column_index_next;
  logic                 run_open, run_open_next;
  logic [COL_BITS-1:0]  run_begin, run_begin_next;
  logic                 held_valid, held_valid_next;
  logic [COL_BITS-1:0]  held_begin, held_begin_next;
  logic [COL_BITS-1:0]  held_finish, held_finish_next;
  logic                 col_on;
  logic                 emit_stale;
  logic [DIFF_BITS-1:0] gap_diff;
  logic [DIFF_BITS-1:0] width_diff;

  always_comb begin
    col_on     = item.green_count >= cfg.green_threshold;
    gap_diff   = DIFF_BITS'(column_index) - DIFF_BITS'(held_finish);
    width_diff = DIFF_BITS'(column_index) - DIFF_BITS'(run_begin);
    emit_stale = !run_open && held_valid && (gap_diff > DIFF_BITS'(cfg.max_row_gap));

    column_index_next = column_index;
    run_open_next     = run_open;
    run_begin_next    = run_begin;
    held_valid_next   = held_valid && !emit_stale;
    held_begin_next   = held_begin;
    held_finish_next  = held_finish;

    if (col_on) begin
      if (!run_open) begin
        if (held_valid_next) begin
          run_begin_next  = held_begin;
          held_valid_next = 1'b0;
        end else begin
          run_begin_next = column_index;
        end
        run_open_next = 1'b1;
      end
    end else if (run_open && (width_diff > DIFF_BITS'(cfg.min_row_width))) begin
      held_valid_next  = 1'b1;
      held_begin_next  = run_begin;
      held_finish_next = column_index;
      run_open_next    = 1'b0;
    end

    res_next.seg_start    = SEG_BITS'(held_begin);
    res_next.seg_end      = SEG_BITS'(held_finish);
    res_next.seg_valid    = emit_stale;
    res_next.section_done = item.last_column;
    res_present           = emit_stale;

    if (item.last_column) begin
      if (!emit_stale) begin
        res_next.seg_valid = held_valid_next;
        res_next.seg_start = held_valid_next ? SEG_BITS'(held_begin_next) : '0;
        res_next.seg_end   = held_valid_next ? SEG_BITS'(held_finish_next) : '0;
      end
      res_present       = 1'b1;
      column_index_next = '0;
      run_open_next     = 1'b0;
      held_valid_next   = 1'b0;
    end else if (column_index < LAST_INDEX) begin
      column_index_next = column_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      run_open     <= 1'b0;
      run_begin    <= '0;
      held_valid   <= 1'b0;
      held_begin   <= '0;
      held_finish  <= '0;
    end else if (step) begin
      column_index <= column_index_next;
      run_open     <= run_open_next;
      run_begin    <= run_begin_next;
      held_valid   <= held_valid_next;
      held_begin   <= held_begin_next;
      held_finish  <= held_finish_next;
    end
  end

endmodule

`default_nettype wire

[design/crs_out_reg.sv]
// ----------------------------------------------------------------------------
// Segment result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_out_reg
  import crs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        res_present,
  input  wire crs_result_t res_next,
  output      logic        drain,
  output      logic        res_valid,
  input  wire logic        res_stall,
  output      crs_result_t res
);

  logic load;

  assign drain = !res_valid || !res_stall;
  assign load  = step && res_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[design/crs_checker.sv]
// ----------------------------------------------------------------------------
// Column run segmenter port checker
// Concurrent checks on the segmenter's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_run_segmenter_defines.svh"

module crs_checker
  import crs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        col_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire crs_result_t res
);

  `CRS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result word present after reset")

  `CRS_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res), "stalled result word changed")

  `CRS_ASSERT(a_no_seg_is_end, clk, rst, res_valid && !res.seg_valid |-> res.section_done && res.seg_start == '0 && res.seg_end == '0, "empty result word is not a clean section end")

  `CRS_ASSERT(a_free_output_takes, clk, rst, !res_valid || !res_stall |-> !col_stall, "column stalled while the result register is free")

endmodule

bind column_run_segmenter crs_checker u_crs_checker (.*);

`default_nettype wire
